@@ hdl/aligned_bitmap_text_rasterizer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the aligned bitmap text rasterizer
// Shared property wrappers: clocked, reset-gated, reporting by $error.
// ---------------------------------------------------------------------------
`ifndef ALIGNED_BITMAP_TEXT_RASTERIZER_ASSERT_SVH
`define ALIGNED_BITMAP_TEXT_RASTERIZER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ABTR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abtr assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ABTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abtr assertion failed");

`endif

@@ hdl/abtr_pkg.sv @@
// ---------------------------------------------------------------------------
// abtr_pkg
// Shared constants, types and font helpers of the text rasterizer.
// ---------------------------------------------------------------------------
package abtr_pkg;

   localparam int GLYPH_COUNT = 96;
   localparam int LARGE_ROWS  = 16;
   localparam int SMALL_ROWS  = 6;
   localparam int MEDIUM_ROWS = 8;
   localparam int MEM_DEPTH   = GLYPH_COUNT * (SMALL_ROWS + MEDIUM_ROWS + LARGE_ROWS);
   localparam int MEM_ADDR_W  = $clog2(MEM_DEPTH);
   localparam int ROW_W       = $clog2(LARGE_ROWS);
   localparam int ROWS_W      = ROW_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] SPACE_CODE = 7'h20;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [1:0] FONT_SMALL  = 2'd0;
   localparam logic [1:0] FONT_MEDIUM = 2'd1;
   localparam logic [1:0] FONT_LARGE  = 2'd2;
   localparam logic [1:0] FONT_RSVD   = 2'd3;

   localparam logic [1:0] ALIGN_START  = 2'd0;
   localparam logic [1:0] ALIGN_MIDDLE = 2'd1;
   localparam logic [1:0] ALIGN_END    = 2'd2;

   // One queued word: a glyph memory write or a classified draw.
   typedef struct packed {
      logic                  is_load;
      logic [MEM_ADDR_W-1:0] addr;     // write address, or glyph base for a draw
      logic [7:0]            wdata;
      logic [7:0]            cell_x;
      logic [7:0]            cell_y;
      logic [1:0]            font;
      logic [15:0]           color;
   } abtr_entry_type;

   typedef struct packed {
      logic           valid;
      abtr_entry_type entry;
   } abtr_push_type;

   typedef struct packed {
      logic           valid;
      logic [QLVL_W-1:0] level;
      abtr_entry_type entry;
   } abtr_head_type;

   function automatic logic [ROWS_W-1:0] font_rows(input logic [1:0] font);
      logic [ROWS_W-1:0] rows;
      case (font)
         FONT_SMALL:  rows = ROWS_W'(SMALL_ROWS);
         FONT_MEDIUM: rows = ROWS_W'(MEDIUM_ROWS);
         default:     rows = ROWS_W'(LARGE_ROWS);
      endcase
      return rows;
   endfunction

   function automatic logic [MEM_ADDR_W-1:0] font_base(input logic [1:0] font);
      logic [MEM_ADDR_W-1:0] base;
      case (font)
         FONT_SMALL:  base = '0;
         FONT_MEDIUM: base = MEM_ADDR_W'(GLYPH_COUNT * SMALL_ROWS);
         default:     base = MEM_ADDR_W'(GLYPH_COUNT * (SMALL_ROWS + MEDIUM_ROWS));
      endcase
      return base;
   endfunction

   // Mirror the used width of a stored row: pixel k is stored bit w-1-k.
   function automatic logic [7:0] row_mask(input logic [7:0] bits, input logic [1:0] font);
      logic [7:0] mask;
      case (font)
         FONT_SMALL:  mask = {4'b0, bits[0], bits[1], bits[2], bits[3]};
         FONT_MEDIUM: mask = {2'b0, bits[0], bits[1], bits[2], bits[3], bits[4], bits[5]};
         default:     mask = {bits[0], bits[1], bits[2], bits[3],
                              bits[4], bits[5], bits[6], bits[7]};
      endcase
      return mask;
   endfunction

endpackage

@@ hdl/abtr_req_if.sv @@
// ---------------------------------------------------------------------------
// abtr_req_if
// Request channel: load or draw words with valid/ready handshake.
// ---------------------------------------------------------------------------
interface abtr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [1:0]  font_id;
   logic [10:0] table_addr;
   logic [7:0]  table_row;
   logic [7:0]  char_code;
   logic [7:0]  char_index;
   logic [7:0]  text_length;
   logic signed [15:0] anchor_x;
   logic signed [15:0] anchor_y;
   logic [1:0]  h_align;
   logic [1:0]  v_align;
   logic [15:0] color;

   modport source (
      output valid, operation, font_id, table_addr, table_row, char_code, char_index,
             text_length, anchor_x, anchor_y, h_align, v_align, color,
      input  ready
   );
   modport sink (
      input  valid, operation, font_id, table_addr, table_row, char_code, char_index,
             text_length, anchor_x, anchor_y, h_align, v_align, color,
      output ready
   );
endinterface

@@ hdl/abtr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// abtr_rsp_if
// Response channel: one glyph row mask word per handshake.
// ---------------------------------------------------------------------------
interface abtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  row_x;
   logic [8:0]  row_y;
   logic [7:0]  row_mask;
   logic [15:0] pixel_color;
   logic        last_row;

   modport source (
      output valid, row_x, row_y, row_mask, pixel_color, last_row,
      input  ready
   );
   modport sink (
      input  valid, row_x, row_y, row_mask, pixel_color, last_row,
      output ready
   );
endinterface

@@ hdl/abtr_front.sv @@
// ---------------------------------------------------------------------------
// abtr_front
// Accept request words, drop ignored ones, work out cell origin and glyph base.
// ---------------------------------------------------------------------------
module abtr_front (
   abtr_req_if.sink               req_chan,
   input  logic                   q_full,
   output abtr_pkg::abtr_push_type push
);
   import abtr_pkg::*;

   logic [ROWS_W-1:0]     rows;
   logic [10:0]           span;
   logic [7:0]            idx_off;
   logic [7:0]            x_left;
   logic [7:0]            y_top;
   logic [6:0]            code7;
   logic [6:0]            glyph;
   logic [MEM_ADDR_W-1:0] glyph_off;
   logic [10:0]           load_limit;
   logic                  keep;

   assign rows  = font_rows(req_chan.font_id);
   assign code7 = req_chan.char_code[6:0];
   assign glyph = (code7 < SPACE_CODE) ? 7'd0 : code7 - SPACE_CODE;

   // Width times length and width times index by shift and add.
   always_comb begin
      case (req_chan.font_id)
         FONT_SMALL: begin
            span       = {1'b0, req_chan.text_length, 2'b00};
            idx_off    = {req_chan.char_index[5:0], 2'b00};
            glyph_off  = MEM_ADDR_W'({glyph, 2'b00}) + MEM_ADDR_W'({glyph, 1'b0});
            load_limit = 11'(GLYPH_COUNT * SMALL_ROWS);
         end
         FONT_MEDIUM: begin
            span       = {1'b0, req_chan.text_length, 2'b00}
                       + {2'b00, req_chan.text_length, 1'b0};
            idx_off    = {req_chan.char_index[5:0], 2'b00} + {req_chan.char_index[6:0], 1'b0};
            glyph_off  = MEM_ADDR_W'({glyph, 3'b000});
            load_limit = 11'(GLYPH_COUNT * MEDIUM_ROWS);
         end
         default: begin
            span       = {req_chan.text_length, 3'b000};
            idx_off    = {req_chan.char_index[4:0], 3'b000};
            glyph_off  = MEM_ADDR_W'({glyph, 4'b0000});
            load_limit = 11'(GLYPH_COUNT * LARGE_ROWS);
         end
      endcase
   end

   always_comb begin
      case (req_chan.h_align)
         ALIGN_START:  x_left = req_chan.anchor_x[7:0];
         ALIGN_MIDDLE: x_left = req_chan.anchor_x[7:0] - span[8:1];
         ALIGN_END:    x_left = req_chan.anchor_x[7:0] - span[7:0];
         default:      x_left = 8'd0;
      endcase
      case (req_chan.v_align)
         ALIGN_START:  y_top = req_chan.anchor_y[7:0];
         ALIGN_MIDDLE: y_top = req_chan.anchor_y[7:0] - 8'(rows[ROWS_W-1:1]);
         ALIGN_END:    y_top = req_chan.anchor_y[7:0] - 8'(rows);
         default:      y_top = 8'd0;
      endcase
   end

   // Drop reserved fonts and loads beyond the font.
   assign keep = (req_chan.font_id != FONT_RSVD)
              && ((req_chan.operation == OP_DRAW) || (req_chan.table_addr < load_limit));

   assign req_chan.ready = !q_full;

   always_comb begin
      push.valid        = req_chan.valid && !q_full && keep;
      push.entry.is_load = (req_chan.operation == OP_LOAD);
      push.entry.addr   = (req_chan.operation == OP_LOAD)
                        ? font_base(req_chan.font_id) + MEM_ADDR_W'(req_chan.table_addr)
                        : font_base(req_chan.font_id) + glyph_off;
      push.entry.wdata  = req_chan.table_row;
      push.entry.cell_x = x_left + idx_off;
      push.entry.cell_y = y_top;
      push.entry.font   = req_chan.font_id;
      push.entry.color  = req_chan.color;
   end

endmodule

@@ hdl/abtr_queue.sv @@
// ---------------------------------------------------------------------------
// abtr_queue
// Short FIFO between the classifying front and the row-emitting back.
// ---------------------------------------------------------------------------
module abtr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  abtr_pkg::abtr_push_type push,
   input  logic                    pop,
   output logic                    full,
   output abtr_pkg::abtr_head_type head
);
   import abtr_pkg::*;

   abtr_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              do_pop;

   assign full   = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign do_pop = pop && (level_ff != '0);

   assign head.valid = (level_ff != '0);
   assign head.level = level_ff;
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !push.valid) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ hdl/abtr_back.sv @@
// ---------------------------------------------------------------------------
// abtr_back
// Glyph memory, row sequencer, read stage and response output register.
// ---------------------------------------------------------------------------
module abtr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  abtr_pkg::abtr_head_type head,
   output logic                    pop,
   abtr_rsp_if.source              rsp_chan
);
   import abtr_pkg::*;

   logic [7:0] glyph_mem [MEM_DEPTH];

   // Current draw being sequenced.
   logic                  cur_v_ff, cur_v_in;
   abtr_entry_type        cur_ff, cur_in;
   logic [ROW_W-1:0]      row_ff, row_in;

   // Read stage: data register of the memory plus row metadata.
   logic                  s1_v_ff, s1_v_in;
   logic [7:0]            rd_data_ff;
   logic [7:0]            s1_x_ff, s1_x_in;
   logic [8:0]            s1_y_ff, s1_y_in;
   logic [1:0]            s1_font_ff, s1_font_in;
   logic [15:0]           s1_color_ff, s1_color_in;
   logic                  s1_last_ff, s1_last_in;

   // Output register.
   logic                  out_v_ff, out_v_in;
   logic [7:0]            out_x_ff, out_x_in;
   logic [8:0]            out_y_ff, out_y_in;
   logic [7:0]            out_mask_ff, out_mask_in;
   logic [15:0]           out_color_ff, out_color_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_load;
   logic                  s1_adv;
   logic                  issue;
   logic                  cur_last;
   logic                  free;
   logic                  mem_we;
   logic [MEM_ADDR_W-1:0] rd_addr;

   assign out_load = !out_v_ff || rsp_chan.ready;
   assign s1_adv   = s1_v_ff && out_load;
   assign issue    = cur_v_ff && (!s1_v_ff || out_load);
   assign cur_last = ({1'b0, row_ff} == font_rows(cur_ff.font) - 1'b1);
   assign free     = !cur_v_ff || (issue && cur_last);
   assign pop      = free && head.valid;
   assign mem_we   = pop && head.entry.is_load;
   assign rd_addr  = cur_ff.addr + MEM_ADDR_W'(row_ff);

   always_comb begin
      cur_v_in = cur_v_ff;
      cur_in   = cur_ff;
      row_in   = row_ff;
      if (pop && !head.entry.is_load) begin
         cur_v_in = 1'b1;
         cur_in   = head.entry;
         row_in   = '0;
      end else if (issue && cur_last) begin
         cur_v_in = 1'b0;
      end else if (issue) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_comb begin
      s1_v_in     = s1_v_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      s1_font_in  = s1_font_ff;
      s1_color_in = s1_color_ff;
      s1_last_in  = s1_last_ff;
      if (issue) begin
         s1_v_in     = 1'b1;
         s1_x_in     = cur_ff.cell_x;
         s1_y_in     = {1'b0, cur_ff.cell_y} + 9'(row_ff);
         s1_font_in  = cur_ff.font;
         s1_color_in = cur_ff.color;
         s1_last_in  = cur_last;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
   end

   always_comb begin
      out_v_in     = out_v_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_mask_in  = out_mask_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (s1_adv) begin
         out_v_in     = 1'b1;
         out_x_in     = s1_x_ff;
         out_y_in     = s1_y_ff;
         out_mask_in  = row_mask(rd_data_ff, s1_font_ff);
         out_color_in = s1_color_ff;
         out_last_in  = s1_last_ff;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         row_ff   <= '0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         cur_v_ff <= cur_v_in;
         row_ff   <= row_in;
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      s1_font_ff   <= s1_font_in;
      s1_color_ff  <= s1_color_in;
      s1_last_ff   <= s1_last_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_mask_ff  <= out_mask_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   // Write loads into the glyph memory; hold the read data while the read stage stalls.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[head.entry.addr] <= head.entry.wdata;
      end
      if (issue) begin
         rd_data_ff <= glyph_mem[rd_addr];
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.row_x       = out_x_ff;
   assign rsp_chan.row_y       = out_y_ff;
   assign rsp_chan.row_mask    = out_mask_ff;
   assign rsp_chan.pixel_color = out_color_ff;
   assign rsp_chan.last_row    = out_last_ff;

endmodule

@@ hdl/aligned_bitmap_text_rasterizer.sv @@
// ---------------------------------------------------------------------------
// aligned_bitmap_text_rasterizer
// Bitmap font character generator: glyph loads and aligned row-mask drawing.
// ---------------------------------------------------------------------------
//
//   channel   | dir | handshake          | one word carries
//   ----------+-----+--------------------+--------------------------------------
//   req_chan  | in  | valid/ready        | glyph row load or one character draw
//   rsp_chan  | out | valid/ready        | one glyph row mask with cell position
//
// A draw word gives 6, 8 or 16 response words (small, medium, large font), one
// per cycle unless the response side stalls; the row sequencer in the back
// part reading one glyph memory row a cycle sets that rate. A load gives no
// response. The first response passes the queue, the sequencer, the read stage
// and the output register. Reset clears the queue, the sequencer and the output
// register; the glyph memory is not cleared and must be loaded before it is
// drawn from. A stalled response holds the read stage and sequencer; the
// two-word queue keeps taking requests until it fills.
// ---------------------------------------------------------------------------
`include "aligned_bitmap_text_rasterizer_assert.svh"

module aligned_bitmap_text_rasterizer (
   input  logic       clock,
   input  logic       reset,
   abtr_req_if.sink   req_chan,
   abtr_rsp_if.source rsp_chan
);
   import abtr_pkg::*;

   abtr_push_type push;
   abtr_head_type head;
   logic          q_full;
   logic          q_pop;

   // Classify: drop ignored words, compute origin and memory address.
   abtr_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   // Decouple the front from the row sequencer.
   abtr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .full  (q_full),
      .head  (head)
   );

   // Execute loads and emit rows.
   abtr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   // Queue level never passes its depth.
   `ABTR_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, head.level <= QLVL_W'(QUEUE_DEPTH))
   // Within a character the next row follows at once after a taken row.
   `ABTR_ASSERT_NEXT(a_row_follows, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_row, rsp_chan.valid)
   // Rows of one character step down by one.
   `ABTR_ASSERT_NEXT(a_row_step, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_row, rsp_chan.row_y == $past(rsp_chan.row_y) + 9'd1)

endmodule

@@ tb/aligned_bitmap_text_rasterizer_tb.sv @@
// ---------------------------------------------------------------------------
// aligned_bitmap_text_rasterizer_tb
// Drives glyph row loads and character draws into the rasterizer, predicts
// every row-mask word from a private copy of the glyph memory, and checks the
// response stream field by field under random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module aligned_bitmap_text_rasterizer_tb;
   import abtr_pkg::*;

   // Alignment code with no defined meaning: that origin coordinate becomes 0.
   localparam logic [1:0] ALIGN_ZERO = 2'd3;

   localparam int WORD_TARGET   = 330;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 40;

   // One request word as the sender sees it.
   typedef struct {
      logic               operation;
      logic [1:0]         font_id;
      logic [10:0]        table_addr;
      logic [7:0]         table_row;
      logic [7:0]         char_code;
      logic [7:0]         char_index;
      logic [7:0]         text_length;
      logic signed [15:0] anchor_x;
      logic signed [15:0] anchor_y;
      logic [1:0]         h_align;
      logic [1:0]         v_align;
      logic [15:0]        color;
   } raster_cmd_type;

   // One row-mask response word.
   typedef struct {
      logic [7:0]  row_x;
      logic [8:0]  row_y;
      logic [7:0]  row_mask;
      logic [15:0] pixel_color;
      logic        last_row;
   } mask_row_type;

   // Glyph memory shadow, row-mask predictor and the queue of rows still due.
   class glyph_raster_model;
      logic [7:0]   glyph_mem [MEM_DEPTH];
      mask_row_type rows_due [$];
      int           errors;

      function int cell_cols(logic [1:0] f);
         case (f)
            FONT_SMALL:  return 4;
            FONT_MEDIUM: return 6;
            default:     return 8;
         endcase
      endfunction

      function int cell_rows(logic [1:0] f);
         case (f)
            FONT_SMALL:  return SMALL_ROWS;
            FONT_MEDIUM: return MEDIUM_ROWS;
            default:     return LARGE_ROWS;
         endcase
      endfunction

      function int font_origin(logic [1:0] f);
         case (f)
            FONT_SMALL:  return 0;
            FONT_MEDIUM: return GLYPH_COUNT * SMALL_ROWS;
            default:     return GLYPH_COUNT * (SMALL_ROWS + MEDIUM_ROWS);
         endcase
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      function void take_word(raster_cmd_type c);
         int           w, h, base, ax, ay, len, idx, xl, yt, glyph;
         logic [7:0]   cx, cy, bits, mask;
         logic [6:0]   code7;
         mask_row_type row;
         if (c.font_id == FONT_RSVD) return;
         w    = cell_cols(c.font_id);
         h    = cell_rows(c.font_id);
         base = font_origin(c.font_id);
         if (c.operation == OP_LOAD) begin
            if (int'(c.table_addr) < GLYPH_COUNT * h)
               glyph_mem[base + int'(c.table_addr)] = c.table_row;
            return;
         end
         ax  = c.anchor_x;
         ay  = c.anchor_y;
         len = int'(c.text_length);
         idx = int'(c.char_index);
         // Only the low byte of the origin survives, so plain int wrap is enough.
         case (c.h_align)
            ALIGN_START:  xl = ax;
            ALIGN_MIDDLE: xl = ax - (w * len) / 2;
            ALIGN_END:    xl = ax - w * len;
            default:      xl = 0;
         endcase
         case (c.v_align)
            ALIGN_START:  yt = ay;
            ALIGN_MIDDLE: yt = ay - h / 2;
            ALIGN_END:    yt = ay - h;
            default:      yt = 0;
         endcase
         cx    = 8'(xl + idx * w);
         cy    = 8'(yt);
         code7 = c.char_code[6:0];
         glyph = (code7 < SPACE_CODE) ? 0 : int'(code7) - int'(SPACE_CODE);
         for (int r = 0; r < h; r++) begin
            bits = glyph_mem[base + glyph * h + r];
            mask = '0;
            for (int k = 0; k < w; k++)
               mask[k] = bits[w - 1 - k];
            row.row_x       = cx;
            row.row_y       = 9'(cy) + 9'(r);
            row.row_mask    = mask;
            row.pixel_color = c.color;
            row.last_row    = (r == h - 1);
            rows_due.push_back(row);
         end
      endfunction

      function void match_row(mask_row_type got);
         mask_row_type want;
         if (rows_due.size() == 0) begin
            $error("unexpected row word: row_x %0d row_y %0d row_mask %h",
                   got.row_x, got.row_y, got.row_mask);
            errors++;
            return;
         end
         want = rows_due.pop_front();
         if (got.row_x !== want.row_x) begin
            $error("row_x: expected %0d, got %0d", want.row_x, got.row_x);
            errors++;
         end
         if (got.row_y !== want.row_y) begin
            $error("row_y: expected %0d, got %0d", want.row_y, got.row_y);
            errors++;
         end
         if (got.row_mask !== want.row_mask) begin
            $error("row_mask: expected %h, got %h", want.row_mask, got.row_mask);
            errors++;
         end
         if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
            errors++;
         end
         if (got.last_row !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   abtr_req_if req_chan ();
   abtr_rsp_if rsp_chan ();

   aligned_bitmap_text_rasterizer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   glyph_raster_model raster = new();

   // Rows loaded so far; a glyph may be drawn only once all its rows are here.
   bit glyph_seen [MEM_DEPTH];
   // High during stretches where neither side idles.
   bit steady;
   // Words that the block acts on (ignored loads and reserved-font words excluded).
   int words_sent;
   int cycles;

   always #5 clock = ~clock;

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("aligned_bitmap_text_rasterizer_tb: done, errors");
         $finish;
      end
   end

   // Fill every field at random; callers override what matters.
   function automatic raster_cmd_type random_cmd();
      raster_cmd_type c;
      c.operation   = 1'($urandom_range(0, 1));
      c.font_id     = 2'($urandom_range(0, 3));
      c.table_addr  = 11'($urandom);
      c.table_row   = 8'($urandom);
      c.char_code   = 8'($urandom);
      c.char_index  = 8'($urandom_range(0, 254));
      c.text_length = 8'($urandom);
      c.anchor_x    = 16'($urandom);
      c.anchor_y    = 16'($urandom);
      c.h_align     = 2'($urandom_range(0, 3));
      c.v_align     = 2'($urandom_range(0, 3));
      c.color       = 16'($urandom);
      return c;
   endfunction

   function automatic raster_cmd_type load_cmd(input logic [1:0] f, input logic [10:0] addr,
                                               input logic [7:0] bits);
      raster_cmd_type c;
      c            = random_cmd();
      c.operation  = OP_LOAD;
      c.font_id    = f;
      c.table_addr = addr;
      c.table_row  = bits;
      return c;
   endfunction

   function automatic raster_cmd_type draw_cmd(input logic [1:0] f, input logic [7:0] code,
                                               input logic [7:0] idx, len,
                                               input logic [15:0] ax, ay,
                                               input logic [1:0] ha, va,
                                               input logic [15:0] col);
      raster_cmd_type c;
      c             = random_cmd();
      c.operation   = OP_DRAW;
      c.font_id     = f;
      c.char_code   = code;
      c.char_index  = idx;
      c.text_length = len;
      c.anchor_x    = ax;
      c.anchor_y    = ay;
      c.h_align     = ha;
      c.v_align     = va;
      c.color       = col;
      return c;
   endfunction

   // Pick a fully loaded glyph of the font at random, or -1 if there is none.
   function automatic int pick_glyph(input logic [1:0] f);
      int  ready_list [$];
      int  h, base;
      bit  whole;
      h    = raster.cell_rows(f);
      base = raster.font_origin(f);
      for (int g = 0; g < GLYPH_COUNT; g++) begin
         whole = 1'b1;
         for (int r = 0; r < h; r++)
            if (!glyph_seen[base + g * h + r]) whole = 1'b0;
         if (whole) ready_list.push_back(g);
      end
      if (ready_list.size() == 0) return -1;
      return ready_list[$urandom_range(0, ready_list.size() - 1)];
   endfunction

   // Character byte that lands on the glyph; glyph 0 also takes control codes.
   function automatic logic [7:0] code_for(input int g);
      logic [7:0] code;
      if (g == 0) code = 8'($urandom_range(0, int'(SPACE_CODE)));
      else        code = 8'(g + int'(SPACE_CODE));
      code[7] = 1'($urandom_range(0, 1));
      return code;
   endfunction

   // Send one word. Call at a falling edge; return at the falling edge after
   // the handshake, so a back-to-back word keeps valid high without a dip.
   task automatic send_word(input raster_cmd_type cmd);
      int gap;
      int h;
      if ($urandom_range(0, 29) == 0) steady = ~steady;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.operation   <= cmd.operation;
      req_chan.font_id     <= cmd.font_id;
      req_chan.table_addr  <= cmd.table_addr;
      req_chan.table_row   <= cmd.table_row;
      req_chan.char_code   <= cmd.char_code;
      req_chan.char_index  <= cmd.char_index;
      req_chan.text_length <= cmd.text_length;
      req_chan.anchor_x    <= cmd.anchor_x;
      req_chan.anchor_y    <= cmd.anchor_y;
      req_chan.h_align     <= cmd.h_align;
      req_chan.v_align     <= cmd.v_align;
      req_chan.color       <= cmd.color;
      req_chan.valid       <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      raster.take_word(cmd);
      // Track loaded rows and count only words the block acts on.
      if (cmd.font_id != FONT_RSVD) begin
         h = raster.cell_rows(cmd.font_id);
         if (cmd.operation == OP_DRAW) begin
            words_sent++;
         end else if (int'(cmd.table_addr) < GLYPH_COUNT * h) begin
            glyph_seen[raster.font_origin(cmd.font_id) + int'(cmd.table_addr)] = 1'b1;
            words_sent++;
         end
      end
      @(negedge clock);
   endtask

   // Hold the sender until every predicted row has come back.
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (raster.pending() != 0) @(negedge clock);
   endtask

   // Load every row of one glyph, top row first, with random pixels.
   task automatic load_glyph(input logic [1:0] f, input int g);
      int h;
      h = raster.cell_rows(f);
      for (int r = 0; r < h; r++)
         send_word(load_cmd(f, 11'(g * h + r), 8'($urandom)));
   endtask

   // Draw a short run of consecutive characters of one string in one font.
   task automatic draw_string();
      raster_cmd_type c;
      logic [1:0]     f;
      int             n, first;
      f = 2'($urandom_range(0, 2));
      if (pick_glyph(f) < 0) load_glyph(f, $urandom_range(0, GLYPH_COUNT - 1));
      n           = $urandom_range(1, 4);
      first       = $urandom_range(0, 255 - n);
      c           = random_cmd();
      c.operation = OP_DRAW;
      c.font_id   = f;
      // Half the strings carry a length that matches the run, half any length.
      if ($urandom_range(0, 1)) c.text_length = 8'(first + n);
      for (int i = 0; i < n; i++) begin
         c.char_index = 8'(first + i);
         c.char_code  = code_for(pick_glyph(f));
         send_word(c);
      end
   endtask

   // Response side: stall at random, then take and check each row word.
   initial begin
      int           stall;
      mask_row_type got;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.row_x       = rsp_chan.row_x;
         got.row_y       = rsp_chan.row_y;
         got.row_mask    = rsp_chan.row_mask;
         got.pixel_color = rsp_chan.pixel_color;
         got.last_row    = rsp_chan.last_row;
         raster.match_row(got);
         @(negedge clock);
      end
   end

   // Stimulus: reset, directed corners, random traffic, then drain and report.
   initial begin
      logic [7:0] small_pattern [SMALL_ROWS];
      int         pick;
      small_pattern = '{8'hFF, 8'h00, 8'hA5, 8'h0F, 8'hF0, 8'h5A};

      // Drive every input to a known value before the first edge.
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_LOAD;
      req_chan.font_id     = FONT_SMALL;
      req_chan.table_addr  = '0;
      req_chan.table_row   = '0;
      req_chan.char_code   = '0;
      req_chan.char_index  = '0;
      req_chan.text_length = '0;
      req_chan.anchor_x    = '0;
      req_chan.anchor_y    = '0;
      req_chan.h_align     = ALIGN_START;
      req_chan.v_align     = ALIGN_START;
      req_chan.color       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Small glyph 0, with rows that also set the unused high bits.
      for (int r = 0; r < SMALL_ROWS; r++)
         send_word(load_cmd(FONT_SMALL, 11'(r), small_pattern[r]));
      // Control code maps to glyph 0; all-zero fields.
      send_word(draw_cmd(FONT_SMALL, 8'h00, 8'd0, 8'd0, 16'h0000, 16'h0000,
                         ALIGN_START, ALIGN_START, 16'h0000));
      // Top bit set on space; widest index and length, anchors at both ends.
      send_word(draw_cmd(FONT_SMALL, 8'hA0, 8'd254, 8'd255, 16'h7FFF, 16'h8000,
                         ALIGN_MIDDLE, ALIGN_MIDDLE, 16'hFFFF));
      send_word(draw_cmd(FONT_SMALL, 8'h1F, 8'd3, 8'd255, 16'h8000, 16'h7FFF,
                         ALIGN_END, ALIGN_END, 16'h8421));
      // Undefined alignment codes pin the origin to 0.
      send_word(draw_cmd(FONT_SMALL, 8'h20, 8'd17, 8'd5, 16'hFFFF, 16'hFFFF,
                         ALIGN_ZERO, ALIGN_ZERO, 16'h1234));
      // Index past the string length; cell left edge wraps, cell top sits near 255.
      send_word(draw_cmd(FONT_SMALL, 8'h9F, 8'd200, 8'd3, 16'h00F0, 16'h00FF,
                         ALIGN_MIDDLE, ALIGN_END, 16'hF800));
      // Loads past the end of the small font must not land in the medium one.
      send_word(load_cmd(FONT_SMALL, 11'd2047, 8'hFF));
      send_word(load_cmd(FONT_SMALL, 11'(GLYPH_COUNT * SMALL_ROWS), 8'h81));
      // Reserved font: both word kinds are dropped.
      send_word(load_cmd(FONT_RSVD, 11'd0, 8'h3C));
      send_word(draw_cmd(FONT_RSVD, 8'h41, 8'd0, 8'd1, 16'h0010, 16'h0010,
                         ALIGN_START, ALIGN_START, 16'h07E0));
      // Last medium glyph ends on the top row of that font's address range.
      load_glyph(FONT_MEDIUM, GLYPH_COUNT - 1);
      send_word(draw_cmd(FONT_MEDIUM, 8'h7F, 8'd1, 8'd2, 16'h0040, 16'h0020,
                         ALIGN_START, ALIGN_START, 16'h001F));
      send_word(draw_cmd(FONT_MEDIUM, 8'hFF, 8'd254, 8'd0, 16'h8000, 16'h8000,
                         ALIGN_END, ALIGN_MIDDLE, 16'hAAAA));

      // Let the block empty completely once before the random traffic.
      wait_drain();

      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            wait_drain();
         end else if (pick < 30) begin
            load_glyph(2'($urandom_range(0, 2)), $urandom_range(0, GLYPH_COUNT - 1));
         end else if (pick < 85) begin
            draw_string();
         end else if (pick < 95) begin
            // Stray load: any font, any address, in range or not.
            send_word(load_cmd(2'($urandom_range(0, 3)), 11'($urandom), 8'($urandom)));
         end else begin
            send_word(draw_cmd(FONT_RSVD, 8'($urandom), 8'($urandom_range(0, 254)),
                               8'($urandom), 16'($urandom), 16'($urandom),
                               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               16'($urandom)));
         end
      end

      // Drop valid, wait out every predicted row, then give stray words time to show.
      req_chan.valid <= 1'b0;
      while (raster.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (raster.errors == 0)
         $display("aligned_bitmap_text_rasterizer_tb: done, clean");
      else
         $display("aligned_bitmap_text_rasterizer_tb: done, errors");
      $finish;
   end

endmodule
